[rtl/sst_pkg.sv]
`default_nettype none
package sst_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned FIFO_DEPTH        = 4;
  localparam int unsigned REC_SLOTS         = 3;
  localparam int unsigned KW_COUNT          = 14;

  // token kinds
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_LBRACK  = 6'd4;
  localparam logic [5:0] K_RBRACK  = 6'd5;
  localparam logic [5:0] K_COMMA   = 6'd6;
  localparam logic [5:0] K_DOT     = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_COLON   = 6'd9;
  localparam logic [5:0] K_PLUS    = 6'd10;
  localparam logic [5:0] K_MINUS   = 6'd11;
  localparam logic [5:0] K_STAR    = 6'd12;
  localparam logic [5:0] K_DIV     = 6'd13;
  localparam logic [5:0] K_PERCENT = 6'd14;
  localparam logic [5:0] K_BANG    = 6'd15;
  localparam logic [5:0] K_NE      = 6'd16;
  localparam logic [5:0] K_ASSIGN  = 6'd17;
  localparam logic [5:0] K_EQEQ    = 6'd18;
  localparam logic [5:0] K_LESS    = 6'd19;
  localparam logic [5:0] K_LE      = 6'd20;
  localparam logic [5:0] K_GREATER = 6'd21;
  localparam logic [5:0] K_GE      = 6'd22;
  localparam logic [5:0] K_AND     = 6'd23;
  localparam logic [5:0] K_OR      = 6'd24;
  localparam logic [5:0] K_STRING  = 6'd25;
  localparam logic [5:0] K_NUMBER  = 6'd26;
  localparam logic [5:0] K_IDENT   = 6'd27;
  localparam logic [5:0] K_KW0     = 6'd28;
  localparam logic [5:0] K_END     = 6'd42;

  // characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    "class", "func", "var", "if", "else", "while", "for",
    "return", "try", "catch", "finally", "true", "false", "null"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd4, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3, 3'd5, 3'd7, 3'd4, 3'd5, 3'd4
  };

  typedef enum logic [4:0] {
    M_IDLE, M_OP_SLASH, M_OP_MINUS, M_OP_BANG, M_OP_EQ, M_OP_LESS, M_OP_GREATER,
    M_OP_AMP, M_OP_BAR, M_IDENT, M_NUM_INT, M_NUM_FRAC, M_EXP0, M_EXP1,
    M_STRING, M_LINE_CMT, M_BLOCK, M_BLOCK_STAR
  } scan_mode_t;

  typedef struct packed {
    logic        record_kind;
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic [7:0]  decoded_char;
  } rec_t;

  typedef struct packed {
    rec_t [REC_SLOTS-1:0]           rec;
    logic [$clog2(REC_SLOTS+1)-1:0] count;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic logic [7:0] kw_char(int unsigned k, logic [2:0] i);
    logic [63:0] t;
    int unsigned sh;
    t = KW_TEXT[k];
    if (i < KW_LEN[k]) begin
      sh = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
      return 8'(t >> sh);
    end
    return 8'h00;
  endfunction

  // keyword flags that survive byte c at index i of the identifier
  function automatic logic [KW_COUNT-1:0] kw_keep(logic [7:0] c, logic [2:0] i, logic i_ok);
    logic [KW_COUNT-1:0] keep;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      keep[k] = i_ok && (i < KW_LEN[k]) && (kw_char(k, i) == c);
    end
    return keep;
  endfunction

  // {hit, kind} for one-byte tokens
  function automatic logic [6:0] single_lookup(logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h7B:   r = {1'b1, K_LBRACE};
      8'h7D:   r = {1'b1, K_RBRACE};
      8'h5B:   r = {1'b1, K_LBRACK};
      8'h5D:   r = {1'b1, K_RBRACK};
      8'h2C:   r = {1'b1, K_COMMA};
      CH_DOT:  r = {1'b1, K_DOT};
      8'h3B:   r = {1'b1, K_SEMI};
      8'h3A:   r = {1'b1, K_COLON};
      CH_PLUS: r = {1'b1, K_PLUS};
      CH_STAR: r = {1'b1, K_STAR};
      8'h25:   r = {1'b1, K_PERCENT};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/sst_in_if.sv]
`default_nettype none
interface sst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_marker;

  modport source (output valid, output source_byte, output end_marker, input ready);
  modport sink   (input valid, input source_byte, input end_marker, output ready);
endinterface
`default_nettype wire

[rtl/sst_out_if.sv]
`default_nettype none
interface sst_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [5:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] token_length;
  logic [31:0] line_number;
  logic [31:0] column_number;
  logic [7:0]  decoded_char;
  logic        last_of_run;

  modport source (output valid, output record_kind, output token_kind, output start_offset,
                  output token_length, output line_number, output column_number,
                  output decoded_char, output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input token_kind, input start_offset,
                  input token_length, input line_number, input column_number,
                  input decoded_char, input last_of_run, output ready);
endinterface
`default_nettype wire

[rtl/sst_fifo.sv]
`default_nettype none
module sst_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sst_pkg::bundle_t      push_data,
  input  logic                  pop,
  output sst_pkg::bundle_t      head,
  output sst_pkg::fifo_status_t status
);
  import sst_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  bundle_t         slots [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(FIFO_DEPTH));
endmodule
`default_nettype wire

[rtl/sst_scan.sv]
`default_nettype none
module sst_scan #(
  parameter int unsigned POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  sst_in_if.sink           byte_in,
  input  logic             room,
  output logic             push,
  output sst_pkg::bundle_t bundle
);
  import sst_pkg::*;

  typedef logic [POSITION_BITS-1:0] pos_t;

  scan_mode_t          mode, mode_next;
  pos_t                ts, ts_next;
  pos_t                pos, pos_next;
  pos_t                ln, ln_next;
  pos_t                col, col_next;
  pos_t                tcol, tcol_next;
  logic [KW_COUNT-1:0] kwf, kwf_next;
  logic                esc, esc_next;
  logic                dot, dot_next;

  rec_t [REC_SLOTS-1:0]           recs;
  logic [$clog2(REC_SLOTS+1)-1:0] n;
  logic       accept;
  logic [7:0] c;
  logic       is_dig, is_alp;
  logic       do_flush, do_fresh, cons, linc, creset;
  pos_t       pos_i, ln_i, col_i, len, idx;
  logic [7:0] sec;
  logic [5:0] k2, ikind;
  logic [6:0] single;

  function automatic pos_t sat_inc(pos_t x);
    return (x == '1) ? x : x + POSITION_BITS'(1);
  endfunction

  function automatic rec_t mk_tok(logic [5:0] kind, pos_t st, pos_t l, pos_t lnv, pos_t cv);
    rec_t r;
    r               = '0;
    r.token_kind    = kind;
    r.start_offset  = 32'(st);
    r.token_length  = 32'(l);
    r.line_number   = 32'(lnv);
    r.column_number = 32'(cv);
    return r;
  endfunction

  function automatic rec_t mk_chr(logic [7:0] ch);
    rec_t r;
    r              = '0;
    r.record_kind  = 1'b1;
    r.token_kind   = K_STRING;
    r.decoded_char = ch;
    return r;
  endfunction

  assign accept       = byte_in.valid && byte_in.ready;
  assign byte_in.ready = room;
  assign c            = byte_in.source_byte;

  always_comb begin
    mode_next = mode; ts_next = ts; pos_next = pos; ln_next = ln; col_next = col;
    tcol_next = tcol; kwf_next = kwf; esc_next = esc; dot_next = dot;
    recs = '0; n = '0;
    do_flush = 1'b0; do_fresh = 1'b0; cons = 1'b0; linc = 1'b0; creset = 1'b0;
    pos_i  = sat_inc(pos);
    ln_i   = sat_inc(ln);
    col_i  = sat_inc(col);
    len    = pos - ts;
    idx    = pos - ts;
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    is_alp = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
    single = single_lookup(c);
    ikind  = K_IDENT;

    unique case (mode)
      M_OP_MINUS:   begin sec = CH_GT;  k2 = K_MINUS; end
      M_OP_BANG:    begin sec = CH_EQ;  k2 = K_NE;    end
      M_OP_EQ:      begin sec = CH_EQ;  k2 = K_EQEQ;  end
      M_OP_LESS:    begin sec = CH_EQ;  k2 = K_LE;    end
      M_OP_GREATER: begin sec = CH_EQ;  k2 = K_GE;    end
      M_OP_AMP:     begin sec = CH_AMP; k2 = K_AND;   end
      default:      begin sec = CH_BAR; k2 = K_OR;    end
    endcase

    if (byte_in.end_marker) begin
      do_flush = 1'b1;
    end else begin
      unique case (mode)
        M_IDLE: do_fresh = 1'b1;
        M_OP_SLASH: begin
          if (c == CH_SLASH) begin
            cons = 1'b1; mode_next = M_LINE_CMT;
          end else if (c == CH_STAR) begin
            cons = 1'b1; mode_next = M_BLOCK;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_OP_MINUS, M_OP_BANG, M_OP_EQ, M_OP_LESS, M_OP_GREATER, M_OP_AMP, M_OP_BAR: begin
          if (c == sec) begin
            cons      = 1'b1;
            recs[n]   = mk_tok(k2, ts, pos_i - ts, ln, tcol);
            n         = n + 1'b1;
            mode_next = M_IDLE;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alp || is_dig) begin
            kwf_next = kwf & kw_keep(c, idx[2:0], (idx >> 3) == '0);
            cons     = 1'b1;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_NUM_INT: begin
          if (dot) begin
            if (is_dig) begin
              cons = 1'b1; dot_next = 1'b0; mode_next = M_NUM_FRAC;
            end else begin
              do_flush = 1'b1; do_fresh = 1'b1;
            end
          end else if (is_dig) begin
            cons = 1'b1;
          end else if (c == CH_DOT) begin
            cons = 1'b1; dot_next = 1'b1;
          end else if (c == CH_LOW_E || c == CH_UP_E) begin
            cons = 1'b1; mode_next = M_EXP0;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_NUM_FRAC: begin
          if (is_dig) begin
            cons = 1'b1;
          end else if (c == CH_LOW_E || c == CH_UP_E) begin
            cons = 1'b1; mode_next = M_EXP0;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_EXP0: begin
          if (is_dig || c == CH_PLUS || c == CH_MINUS) begin
            cons = 1'b1; mode_next = M_EXP1;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_EXP1: begin
          if (is_dig) begin
            cons = 1'b1;
          end else begin
            do_flush = 1'b1; do_fresh = 1'b1;
          end
        end
        M_STRING: begin
          cons = 1'b1;
          if (esc) begin
            recs[n]  = mk_chr((c == CH_LOW_N) ? CH_LF : (c == CH_LOW_T) ? CH_TAB :
                              (c == CH_LOW_R) ? CH_CR : c);
            n        = n + 1'b1;
            esc_next = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (c == CH_QUOTE) begin
            recs[n]   = mk_tok(K_STRING, ts, pos_i - ts, ln, tcol);
            n         = n + 1'b1;
            mode_next = M_IDLE;
          end else begin
            recs[n] = mk_chr(c);
            n       = n + 1'b1;
            linc    = (c == CH_LF);
          end
        end
        M_LINE_CMT: begin
          cons = 1'b1;
          if (c == CH_LF) begin
            mode_next = M_IDLE; linc = 1'b1; creset = 1'b1;
          end
        end
        M_BLOCK: begin
          if (c == CH_STAR) mode_next = M_BLOCK_STAR;
          cons = 1'b1; linc = (c == CH_LF); creset = (c == CH_LF);
        end
        M_BLOCK_STAR: begin
          if (c == CH_SLASH)     mode_next = M_IDLE;
          else if (c != CH_STAR) mode_next = M_BLOCK;
          cons = 1'b1; linc = (c == CH_LF); creset = (c == CH_LF);
        end
        default: begin
          mode_next = M_IDLE; do_fresh = 1'b1;
        end
      endcase
    end

    // close the pending token with counters from before this byte
    if (do_flush) begin
      unique case (mode)
        M_OP_SLASH:   begin recs[n] = mk_tok(K_DIV, ts, len, ln, tcol);     n = n + 1'b1; end
        M_OP_MINUS:   begin recs[n] = mk_tok(K_MINUS, ts, len, ln, tcol);   n = n + 1'b1; end
        M_OP_BANG:    begin recs[n] = mk_tok(K_BANG, ts, len, ln, tcol);    n = n + 1'b1; end
        M_OP_EQ:      begin recs[n] = mk_tok(K_ASSIGN, ts, len, ln, tcol);  n = n + 1'b1; end
        M_OP_LESS:    begin recs[n] = mk_tok(K_LESS, ts, len, ln, tcol);    n = n + 1'b1; end
        M_OP_GREATER: begin recs[n] = mk_tok(K_GREATER, ts, len, ln, tcol); n = n + 1'b1; end
        M_IDENT: begin
          for (int unsigned k = 0; k < KW_COUNT; k++) begin
            if (kwf[k] && len == pos_t'(KW_LEN[k])) ikind = K_KW0 + 6'(k);
          end
          recs[n] = mk_tok(ikind, ts, len, ln, tcol);
          n       = n + 1'b1;
        end
        M_NUM_INT, M_NUM_FRAC, M_EXP0, M_EXP1: begin
          if (dot && len != '0) begin
            recs[n] = mk_tok(K_NUMBER, ts, len - POSITION_BITS'(1), ln, tcol);
            n       = n + 1'b1;
            recs[n] = mk_tok(K_DOT, pos - POSITION_BITS'(1), POSITION_BITS'(1), ln,
                             (col != '0) ? col - POSITION_BITS'(1) : '0);
            n       = n + 1'b1;
          end else begin
            recs[n] = mk_tok(K_NUMBER, ts, len, ln, tcol);
            n       = n + 1'b1;
          end
        end
        default: ;
      endcase
      mode_next = M_IDLE;
      dot_next  = 1'b0;
      esc_next  = 1'b0;
    end

    // open a new token at this byte
    if (do_fresh) begin
      ts_next   = pos;
      tcol_next = col;
      mode_next = M_IDLE;
      cons      = 1'b1;
      if (single[6]) begin
        recs[n] = mk_tok(single[5:0], pos, pos_i - pos, ln, col);
        n       = n + 1'b1;
      end else begin
        unique case (c)
          CH_SLASH: mode_next = M_OP_SLASH;
          CH_MINUS: mode_next = M_OP_MINUS;
          CH_BANG:  mode_next = M_OP_BANG;
          CH_EQ:    mode_next = M_OP_EQ;
          CH_LT:    mode_next = M_OP_LESS;
          CH_GT:    mode_next = M_OP_GREATER;
          CH_AMP:   mode_next = M_OP_AMP;
          CH_BAR:   mode_next = M_OP_BAR;
          CH_LF:    begin linc = 1'b1; creset = 1'b1; end
          CH_QUOTE: begin mode_next = M_STRING; esc_next = 1'b0; end
          default: begin
            if (is_dig) begin
              mode_next = M_NUM_INT; dot_next = 1'b0;
            end else if (is_alp) begin
              mode_next = M_IDENT;
              kwf_next  = kw_keep(c, 3'd0, 1'b1);
            end
          end
        endcase
      end
    end

    if (cons) begin
      pos_next = pos_i;
      if (linc) ln_next = ln_i;
      col_next = creset ? '0 : col_i;
    end

    if (byte_in.end_marker) begin
      recs[n]   = mk_tok(K_END, pos, '0, ln, col);
      n         = n + 1'b1;
      mode_next = M_IDLE;
      ts_next = '0; pos_next = '0; ln_next = '0; col_next = '0; tcol_next = '0;
      kwf_next = '1; esc_next = 1'b0; dot_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      ts <= '0; pos <= '0; ln <= '0; col <= '0; tcol <= '0;
      kwf <= '1; esc <= 1'b0; dot <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      ts <= ts_next; pos <= pos_next; ln <= ln_next; col <= col_next; tcol <= tcol_next;
      kwf <= kwf_next; esc <= esc_next; dot <= dot_next;
    end
  end

  assign push         = accept && (n != '0);
  assign bundle.rec   = recs;
  assign bundle.count = n;
endmodule
`default_nettype wire

[rtl/sst_emit.sv]
`default_nettype none
module sst_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  sst_pkg::bundle_t      head,
  input  sst_pkg::fifo_status_t status,
  output logic                  pop,
  sst_out_if.source             token_out
);
  import sst_pkg::*;

  localparam int unsigned SW = $clog2(REC_SLOTS + 1);

  logic [SW-1:0] sub;
  rec_t          cur;
  logic          last;

  assign cur  = head.rec[sub[$clog2(REC_SLOTS)-1:0]];
  assign last = (sub == head.count - SW'(1));
  assign pop  = token_out.valid && token_out.ready && last;

  // walk the records of the head bundle, one beat each
  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= '0;
    end else if (token_out.valid && token_out.ready) begin
      sub <= last ? '0 : sub + SW'(1);
    end
  end

  assign token_out.valid         = !status.empty;
  assign token_out.record_kind   = cur.record_kind;
  assign token_out.token_kind    = cur.token_kind;
  assign token_out.start_offset  = cur.start_offset;
  assign token_out.token_length  = cur.token_length;
  assign token_out.line_number   = cur.line_number;
  assign token_out.column_number = cur.column_number;
  assign token_out.decoded_char  = cur.decoded_char;
  assign token_out.last_of_run   = last;
endmodule
`default_nettype wire

[rtl/script_source_tokenizer.sv]
// Lexical scanner for a small scripting language.
// byte_in: one source byte per beat, or a beat with end_marker set that
//   closes the source. token_out: one record per beat, either a token
//   record (kind, start offset, length, line, start column) or a decoded
//   string character; last_of_run marks the final record caused by one
//   input beat. A byte may cause no record, one, or up to three.
// Throughput: one input beat per cycle while the queue is not full. The
//   output side moves one record per cycle while the receiver is ready, and
//   a four-deep queue of per-byte record groups absorbs multi-record bursts.
// Latency: the first record that a byte completes appears on token_out in the
//   cycle after that byte is taken, when the queue was empty.
// The scanner decides everything for a byte in its accept cycle and pushes
//   the group into the queue; byte_in.ready drops only while the queue is full.
// Reset (rst, synchronous): scanner back to idle with all counters zero,
//   queue emptied. An end-marker beat emits pending tokens and END, then
//   returns the scanner to the same state, so a new source may follow.
// When the receiver stalls, the current record holds on token_out, the queue
//   fills, then byte_in stalls; nothing is lost or repeated.
`default_nettype none
module script_source_tokenizer #(
  parameter int unsigned POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sst_in_if.sink    byte_in,
  sst_out_if.source token_out
);
  import sst_pkg::*;

  bundle_t      push_data;
  bundle_t      head;
  fifo_status_t fstat;
  logic         push;
  logic         pop;

  // front: classify each byte, advance counters, build its record group
  sst_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
    .clk    (clk),
    .rst    (rst),
    .byte_in(byte_in),
    .room   (!fstat.full),
    .push   (push),
    .bundle (push_data)
  );

  // hold groups between front and back
  sst_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .status   (fstat)
  );

  // back: drain the head group one record per beat
  sst_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .status   (fstat),
    .pop      (pop),
    .token_out(token_out)
  );

  a_char_rec: assert property (@(posedge clk) disable iff (rst)
    token_out.valid && token_out.record_kind |->
      token_out.token_kind == K_STRING && token_out.start_offset == 32'd0)
    else $error("character record with bad fields");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    token_out.valid && !token_out.record_kind && token_out.token_kind == K_END |->
      token_out.last_of_run)
    else $error("END record not last of its run");

  a_fifo_sane: assert property (@(posedge clk) disable iff (rst)
    !(fstat.full && fstat.empty))
    else $error("queue both full and empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    fstat.full && !pop |=> fstat.full)
    else $error("queue lost a group while full");
endmodule
`default_nettype wire
